/* src/lbe_pkg.sv */
package lbe_pkg;

  // Widths of the fixed-point words
  localparam int TimeW  = 32;
  localparam int OrderW = 4;
  localparam int ValW   = 18;
  localparam int AccW   = 19;
  localparam int CoefW  = 17;
  localparam int MulW   = 33;
  localparam int ProdW  = 66;

  // Configuration register indexes
  localparam logic [1:0] REG_TIME_OFFSET = 2'd0;
  localparam logic [1:0] REG_TIME_SCALE  = 2'd1;
  localparam logic [1:0] REG_NUM_ORDERS  = 2'd2;

  // Q2.16 constants
  localparam logic signed [ValW-1:0] ONE_Q16   = 18'sd65536;
  localparam logic signed [ValW-1:0] MINUS_ONE = -18'sd65536;
  localparam logic signed [ValW-1:0] VAL_MAX   = 18'sd131071;
  localparam logic signed [ValW-1:0] VAL_MIN   = -18'sd131072;

  // Classified sample on its way to the back end
  typedef struct packed {
    logic [TimeW-1:0] diff;
    logic             below;
  } lbe_work_t;

  // One result word
  typedef struct packed {
    logic [OrderW-1:0]      order;
    logic signed [ValW-1:0] poly_value;
    logic                   last;
  } lbe_result_t;

  // Settings the back end works with
  typedef struct packed {
    logic [TimeW-1:0]  time_scale;
    logic [OrderW-1:0] top_order;
  } lbe_cfg_t;

  // (2n-1)/n in unsigned Q1.16, rounded to nearest, ties up
  function automatic logic [CoefW-1:0] lbe_coef_c1(input logic [OrderW-1:0] n);
    logic [CoefW-1:0] c;
    case (n)
      4'd2:    c = 17'd98304;
      4'd3:    c = 17'd109227;
      4'd4:    c = 17'd114688;
      4'd5:    c = 17'd117965;
      4'd6:    c = 17'd120149;
      4'd7:    c = 17'd121710;
      4'd8:    c = 17'd122880;
      4'd9:    c = 17'd123790;
      4'd10:   c = 17'd124518;
      4'd11:   c = 17'd125114;
      4'd12:   c = 17'd125611;
      4'd13:   c = 17'd126031;
      4'd14:   c = 17'd126391;
      4'd15:   c = 17'd126703;
      default: c = '0;
    endcase
    return c;
  endfunction

  // (n-1)/n in unsigned Q1.16, rounded to nearest, ties up
  function automatic logic [CoefW-1:0] lbe_coef_c2(input logic [OrderW-1:0] n);
    logic [CoefW-1:0] c;
    case (n)
      4'd2:    c = 17'd32768;
      4'd3:    c = 17'd43691;
      4'd4:    c = 17'd49152;
      4'd5:    c = 17'd52429;
      4'd6:    c = 17'd54613;
      4'd7:    c = 17'd56174;
      4'd8:    c = 17'd57344;
      4'd9:    c = 17'd58254;
      4'd10:   c = 17'd58982;
      4'd11:   c = 17'd59578;
      4'd12:   c = 17'd60075;
      4'd13:   c = 17'd60495;
      4'd14:   c = 17'd60855;
      4'd15:   c = 17'd61167;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Drop 16 fraction bits, round to nearest with ties toward plus infinity
  function automatic logic [ProdW-17:0] lbe_rnd16(input logic signed [ProdW-1:0] v);
    logic signed [ProdW-1:0] t;
    t = v + 66'sd32768;
    return t[ProdW-1:16];
  endfunction

endpackage

/* src/legendre_basis_evaluator_core.sv */
// Legendre basis evaluator: each time sample pushed in is shifted by time_offset, scaled
// by time_scale onto x in [-1,1] (clamped), and produces the Legendre values P0(x) up to
// PN(x), N = min(num_orders, MAX_ORDER), as N+1 result words in order, the final one
// marked by last. Values are signed Q2.16 from Bonnet's recursion with rounding to
// nearest after every product and saturation of each order. In the back-end sequencer a
// sample passes through the scaling multiply, the clamp and the first word; order one
// needs no multiply, and every higher order passes through states MA1, R1, MA2 and SUM,
// paced by the one shared 33x33 multiplier used three times per order with a rounding
// register between dependent products. A two-word queue on each side lets samples be
// pushed and results be held without stalling the other side. Write the registers only
// while no sample is in flight.
module legendre_basis_evaluator_core #(
  parameter int MAX_ORDER = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [31:0]        time_sample,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         order,
  output logic signed [17:0] poly_value,
  output logic               last,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int QueueDepth = 2;
  localparam logic [5:0] MaxOrderW = 6'(MAX_ORDER);

  logic [31:0]          time_offset;
  logic [31:0]          time_scale;
  logic [3:0]           num_orders;
  lbe_pkg::lbe_cfg_t    cfg;

  logic                 wq_push;
  lbe_pkg::lbe_work_t   wq_in;
  logic                 wq_full;
  logic                 wq_pop;
  lbe_pkg::lbe_work_t   wq_out;
  logic                 wq_empty;

  logic                 rq_push;
  lbe_pkg::lbe_result_t rq_in;
  logic                 rq_full;
  lbe_pkg::lbe_result_t rq_out;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_offset <= '0;
      time_scale  <= '0;
      num_orders  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        lbe_pkg::REG_TIME_OFFSET: time_offset <= cfg_data;
        lbe_pkg::REG_TIME_SCALE:  time_scale  <= cfg_data;
        lbe_pkg::REG_NUM_ORDERS:  num_orders  <= cfg_data[3:0];
        default:                  time_offset <= time_offset;
      endcase
    end
  end

  // Limit the top order to what the build supports
  assign cfg.time_scale = time_scale;
  assign cfg.top_order  = ({2'b0, num_orders} > MaxOrderW) ? MaxOrderW[3:0] : num_orders;

  lbe_front u_front (
    .push        (push),
    .full        (full),
    .time_sample (time_sample),
    .time_offset (time_offset),
    .q_full      (wq_full),
    .q_push      (wq_push),
    .q_item      (wq_in)
  );

  lbe_fifo #(
    .WIDTH ($bits(lbe_pkg::lbe_work_t)),
    .DEPTH (QueueDepth)
  ) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .push  (wq_push),
    .wdata (wq_in),
    .full  (wq_full),
    .pop   (wq_pop),
    .rdata (wq_out),
    .empty (wq_empty)
  );

  lbe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (wq_empty),
    .q_item  (wq_out),
    .q_pop   (wq_pop),
    .o_full  (rq_full),
    .o_push  (rq_push),
    .o_item  (rq_in)
  );

  lbe_fifo #(
    .WIDTH ($bits(lbe_pkg::lbe_result_t)),
    .DEPTH (QueueDepth)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .wdata (rq_in),
    .full  (rq_full),
    .pop   (pop),
    .rdata (rq_out),
    .empty (empty)
  );

  assign order      = rq_out.order;
  assign poly_value = rq_out.poly_value;
  assign last       = rq_out.last;

endmodule

/* src/lbe_fifo.sv */
module lbe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/lbe_front.sv */
module lbe_front (
  input  logic                  push,
  output logic                  full,
  input  logic [31:0]           time_sample,
  input  logic [31:0]           time_offset,
  input  logic                  q_full,
  output logic                  q_push,
  output lbe_pkg::lbe_work_t    q_item
);

  // Take a sample whenever the work queue has room
  assign full   = q_full;
  assign q_push = push && !q_full;

  // Remove the offset and flag samples that fall before it
  assign q_item.diff  = time_sample - time_offset;
  assign q_item.below = (time_sample < time_offset);

endmodule

/* src/lbe_back.sv */
module lbe_back (
  input  logic                  clk,
  input  logic                  rst,
  input  lbe_pkg::lbe_cfg_t     cfg,
  input  logic                  q_empty,
  input  lbe_pkg::lbe_work_t    q_item,
  output logic                  q_pop,
  input  logic                  o_full,
  output logic                  o_push,
  output lbe_pkg::lbe_result_t  o_item
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAP   = 3'd1;
  localparam logic [2:0] S_XCALC = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_MA1   = 3'd4;
  localparam logic [2:0] S_R1    = 3'd5;
  localparam logic [2:0] S_MA2   = 3'd6;
  localparam logic [2:0] S_SUM   = 3'd7;

  logic [2:0]                                state;
  logic [31:0]                               d_reg;
  logic                                      below_reg;
  logic signed [lbe_pkg::ValW-1:0]           norm_x;
  logic signed [lbe_pkg::ValW-1:0]           prev_value;
  logic signed [lbe_pkg::ValW-1:0]           prev_prev_value;
  logic [lbe_pkg::OrderW-1:0]                order_count;
  logic signed [lbe_pkg::ValW-1:0]           val;
  logic signed [lbe_pkg::AccW-1:0]           a1;
  logic signed [lbe_pkg::AccW-1:0]           b_term;
  logic signed [lbe_pkg::ProdW-1:0]          prod;

  logic signed [lbe_pkg::MulW-1:0]           op_a;
  logic signed [lbe_pkg::MulW-1:0]           op_b;
  logic [lbe_pkg::ProdW-17:0]                prod_rnd;
  logic [40:0]                               map_u;
  logic signed [lbe_pkg::ValW-1:0]           map_x;
  logic signed [lbe_pkg::AccW-1:0]           a_term;
  logic signed [lbe_pkg::AccW:0]             diff;
  logic signed [lbe_pkg::ValW-1:0]           sat_val;
  logic [lbe_pkg::CoefW-1:0]                 c1;
  logic [lbe_pkg::CoefW-1:0]                 c2;
  logic                                      is_last;

  assign c1       = lbe_pkg::lbe_coef_c1(order_count);
  assign c2       = lbe_pkg::lbe_coef_c2(order_count);
  assign prod_rnd = lbe_pkg::lbe_rnd16(prod);
  assign is_last  = (order_count == cfg.top_order);

  assign q_pop  = (state == S_IDLE) && !q_empty;
  assign o_push = (state == S_EMIT) && !o_full;

  assign o_item.order      = order_count;
  assign o_item.poly_value = val;
  assign o_item.last       = is_last;

  // Select operands of the shared multiplier
  always_comb begin
    case (state)
      S_MAP: begin
        op_a = $signed({1'b0, d_reg});
        op_b = $signed({1'b0, cfg.time_scale});
      end
      S_MA1: begin
        op_a = $signed({{15{norm_x[17]}}, norm_x});
        op_b = $signed({{15{prev_value[17]}}, prev_value});
      end
      S_R1: begin
        op_a = $signed({16'b0, c2});
        op_b = $signed({{15{prev_prev_value[17]}}, prev_prev_value});
      end
      S_MA2: begin
        op_a = $signed({{14{a1[18]}}, a1});
        op_b = $signed({16'b0, c1});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Round the Q24.40 scaled time to Q.16, clamp to [0,2] and shift down by one
  always_comb begin
    map_u = {1'b0, prod[63:24]} + {40'b0, prod[23]};
    if (below_reg) begin
      map_x = lbe_pkg::MINUS_ONE;
    end else if (map_u >= 41'd131072) begin
      map_x = lbe_pkg::ONE_Q16;
    end else begin
      map_x = $signed({1'b0, map_u[16:0]}) - lbe_pkg::ONE_Q16;
    end
  end

  // Combine the two recursion terms and saturate
  always_comb begin
    a_term = $signed(prod_rnd[18:0]);
    diff   = $signed({a_term[18], a_term}) - $signed({b_term[18], b_term});
    if (diff > 20'sd131071) begin
      sat_val = lbe_pkg::VAL_MAX;
    end else if (diff < -20'sd131072) begin
      sat_val = lbe_pkg::VAL_MIN;
    end else begin
      sat_val = diff[17:0];
    end
  end

  // Multiply every cycle; the sequencer picks up the product it needs
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // Sequence one sample through mapping and the recursion
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      order_count     <= '0;
      norm_x          <= '0;
      prev_value      <= '0;
      prev_prev_value <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            d_reg     <= q_item.diff;
            below_reg <= q_item.below;
            state     <= S_MAP;
          end
        end
        S_MAP: begin
          state <= S_XCALC;
        end
        S_XCALC: begin
          norm_x          <= map_x;
          prev_prev_value <= '0;
          prev_value      <= lbe_pkg::ONE_Q16;
          val             <= lbe_pkg::ONE_Q16;
          order_count     <= '0;
          state           <= S_EMIT;
        end
        S_EMIT: begin
          if (!o_full) begin
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              order_count <= order_count + 1'b1;
              if (order_count == '0) begin
                val             <= norm_x;
                prev_prev_value <= prev_value;
                prev_value      <= norm_x;
              end else begin
                state <= S_MA1;
              end
            end
          end
        end
        S_MA1: begin
          state <= S_R1;
        end
        S_R1: begin
          a1    <= prod_rnd[18:0];
          state <= S_MA2;
        end
        S_MA2: begin
          b_term <= prod_rnd[18:0];
          state  <= S_SUM;
        end
        S_SUM: begin
          val             <= sat_val;
          prev_prev_value <= prev_value;
          prev_value      <= sat_val;
          state           <= S_EMIT;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The order being worked on never passes the top order
  a_order_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_MAP && state != S_XCALC) |->
      (order_count <= cfg.top_order))
    else $error("order count beyond top order");

  // Orders of one sample come out one apart
  a_order_step: assert property (@(posedge clk) disable iff (rst)
    (o_push && !o_item.last) |=> (order_count == $past(order_count) + 1'b1))
    else $error("order did not advance by one");

  // The final order releases the sequencer
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (o_push && o_item.last) |=> (state == S_IDLE))
    else $error("sequencer busy after final order");

  // The mapped sample stays inside [-1,1]
  a_x_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (norm_x >= -18'sd65536 && norm_x <= 18'sd65536))
    else $error("mapped sample out of range");
`endif

endmodule

/* tb/sv/legendre_row_checker.sv */
module legendre_row_checker #(
  parameter int MAX_ORDER = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic [31:0]        time_sample,
  input  logic               empty,
  input  logic               pop,
  input  logic [3:0]         order,
  input  logic signed [17:0] poly_value,
  input  logic               last,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copies of the registers
  logic [31:0] time_base;
  logic [31:0] time_gain;
  logic [3:0]  order_cap;

  // Words still owed by the block, oldest first
  lbe_pkg::lbe_result_t expected_row[$];

  // Drop 16 fraction bits, nearest with ties toward plus infinity
  function automatic longint round_q16(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  // Work out every Legendre word one sample produces
  function automatic void predict_row(input logic [31:0] t);
    logic [31:0] diff;
    logic [63:0] prod;
    logic [63:0] u;
    longint      x;
    longint      v1;
    longint      v2;
    longint      a;
    longint      b;
    longint      p;
    longint      c1;
    longint      c2;
    int          top;
    lbe_pkg::lbe_result_t w;

    // Map onto [-1,1], clamp at both ends
    if (t < time_base) begin
      x = -65536;
    end else begin
      diff = t - time_base;
      prod = {32'd0, diff} * {32'd0, time_gain};
      u = (prod >> 24) + prod[23];
      x = (u >= 64'd131072) ? 65536 : longint'(u) - 65536;
    end

    top = (order_cap > MAX_ORDER) ? MAX_ORDER : order_cap;
    v2 = 0;
    v1 = 65536;
    w.order = '0;
    w.poly_value = lbe_pkg::ONE_Q16;
    w.last = (top == 0);
    expected_row.push_back(w);

    if (top >= 1) begin
      v2 = v1;
      v1 = x;
      w.order = 4'd1;
      w.poly_value = x[17:0];
      w.last = (top == 1);
      expected_row.push_back(w);
    end

    // Bonnet step: round after each product, saturate each order
    for (int n = 2; n <= top; n++) begin
      c1 = ((2 * n - 1) * 131072 + n) / (2 * n);
      c2 = ((n - 1) * 131072 + n) / (2 * n);
      a = round_q16(x * v1);
      a = round_q16(a * c1);
      b = round_q16(c2 * v2);
      p = a - b;
      if (p > lbe_pkg::VAL_MAX) p = lbe_pkg::VAL_MAX;
      else if (p < lbe_pkg::VAL_MIN) p = lbe_pkg::VAL_MIN;
      v2 = v1;
      v1 = p;
      w.order = n[3:0];
      w.poly_value = p[17:0];
      w.last = (n == top);
      expected_row.push_back(w);
    end
  endfunction

  task automatic report_miss(input string what);
    errors++;
    if (errors <= 40) $display("%0t ns  mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    lbe_pkg::lbe_result_t w;
    if (rst) begin
      time_base = '0;
      time_gain = '0;
      order_cap = '0;
      expected_row.delete();
    end else begin
      // Compare each popped word with the oldest prediction
      if (pop && !empty) begin
        if (expected_row.size() == 0) begin
          report_miss($sformatf("unexpected word, order %0d value %0d", order, poly_value));
        end else begin
          w = expected_row.pop_front();
          if (order !== w.order)
            report_miss($sformatf("order %0d, want %0d", order, w.order));
          if (poly_value !== w.poly_value)
            report_miss($sformatf("order %0d value %0d, want %0d",
                                  w.order, poly_value, w.poly_value));
          if (last !== w.last)
            report_miss($sformatf("order %0d last %b, want %b", w.order, last, w.last));
        end
      end

      // Follow register writes; the spare index holds nothing
      if (cfg_write) begin
        case (cfg_index)
          lbe_pkg::REG_TIME_OFFSET: time_base = cfg_data;
          lbe_pkg::REG_TIME_SCALE:  time_gain = cfg_data;
          lbe_pkg::REG_NUM_ORDERS:  order_cap = cfg_data[3:0];
          default: ;
        endcase
      end

      // Predict the whole row for each accepted sample
      if (push && !full) predict_row(time_sample);
    end
    pending = expected_row.size();
  end

endmodule

/* tb/sv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ORDER = 15;
  localparam int STALL_LIMIT = 3000;
  // Index with no register behind it
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic [31:0]        time_sample = '0;
  logic               pop = 1'b0;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               full;
  logic               empty;
  logic [3:0]         order;
  logic signed [17:0] poly_value;
  logic               last;
  int                 errors;
  int                 pending;
  int                 idle_cycles = 0;
  int                 pop_hold = 0;
  bit                 push_steady = 1'b0;
  bit                 pop_steady = 1'b0;

  legendre_basis_evaluator_core #(.MAX_ORDER(MAX_ORDER)) i_dut (.*);

  legendre_row_checker #(.MAX_ORDER(MAX_ORDER)) i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drain result words with random stalls, or steadily in one of the random phases
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      pop <= 1'b1;
      if (!pop_steady) begin
        if ($urandom_range(0, 49) == 0) pop_hold <= $urandom_range(20, 60);
        else if ($urandom_range(0, 5) == 0) pop_hold <= $urandom_range(1, 3);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one sample, hold until taken, then maybe idle a while
  task automatic send_sample(input logic [31:0] t);
    int roll;
    int gap;
    @(negedge clk);
    push <= 1'b1;
    time_sample <= t;
    @(posedge clk);
    while (full) @(posedge clk);
    gap = 0;
    if (!push_steady) begin
      roll = $urandom_range(0, 99);
      if (roll >= 90) gap = $urandom_range(15, 50);
      else if (roll >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every predicted word has been popped
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Reprogram all registers once the block has gone quiet
  task automatic set_range(input logic [31:0] off, input logic [31:0] gain,
                           input logic [3:0] top);
    logic [31:0] junk;
    junk = $urandom();
    drain();
    write_reg(lbe_pkg::REG_TIME_OFFSET, off);
    write_reg(lbe_pkg::REG_TIME_SCALE, gain);
    write_reg(lbe_pkg::REG_NUM_ORDERS, {junk[31:4], top});
    write_reg(REG_SPARE, $urandom());
  endtask

  initial begin
    logic [31:0] base;
    logic [31:0] span;
    logic [31:0] t;
    longint      wide;
    int          roll;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero scale out of reset: every sample sits at -1, order 0 only
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample($urandom());

    // Order count masked to four bits; spare index ignored
    drain();
    write_reg(lbe_pkg::REG_NUM_ORDERS, 32'hFFFF_FFF1);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_sample(32'h0001_0000);

    // Sixteen time units from one, all orders: below, ends, tie, middle, above
    set_range(32'h0001_0000, 32'h0020_0000, 4'd15);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_FFFF);
    send_sample(32'h0001_0000);
    send_sample(32'h0001_0004);
    send_sample(32'h0005_0000);
    send_sample(32'h0009_0000);
    send_sample(32'h000D_0000);
    send_sample(32'h0011_0000);
    send_sample(32'h0011_0001);
    send_sample(32'hFFFF_FFFF);

    // Largest offset and scale
    set_range(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd2);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFE);
    send_sample(32'hFFFF_FFFF);

    // Largest scale from zero: tiny steps already cover most of [-1,1]
    set_range(32'h0000_0000, 32'hFFFF_FFFF, 4'd15);
    send_sample(32'h0000_0001);
    send_sample(32'h0000_0100);
    send_sample(32'h0000_01FF);

    // Exact rounding tie in the time mapping
    set_range(32'h0000_0000, 32'h0080_0000, 4'd15);
    send_sample(32'h0000_0001);

    // Random windows, mostly samples inside them
    for (int ph = 0; ph < 5; ph++) begin
      span = ($urandom() | 32'h8000_0000) >> $urandom_range(0, 21);
      base = $urandom();
      wide = (64'd1 << 41) / span;
      push_steady = (ph == 2);
      pop_steady = (ph == 3);
      set_range(base, wide[31:0], (ph == 4) ? 4'd15 : 4'($urandom_range(0, 15)));
      repeat (18) begin
        roll = $urandom_range(0, 9);
        if (roll < 8) t = base + $urandom_range(0, span);
        else if (roll == 8) t = $urandom();
        else t = base + $urandom_range(0, 8) - 4;
        send_sample(t);
      end
    end

    // Let any stray words surface before the verdict
    drain();
    repeat (80) @(negedge clk);

    if (errors == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* legendre_basis_evaluator_core.f */
src/lbe_pkg.sv
src/lbe_fifo.sv
src/lbe_front.sv
src/lbe_back.sv
src/legendre_basis_evaluator_core.sv
tb/sv/legendre_row_checker.sv
tb/sv/tb.sv
